/* rtl/dlr_pkg.sv */
// dotted line rasterizer package: default sizes, request codes and the
// command and status structs between controller and datapath
// no dependencies

package dlr_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int PERIOD_WIDTH    = 8;
   localparam int COLOR_WIDTH     = 8;

   // request kinds carried on req_tuser
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   typedef struct packed {
      logic load;      // latch endpoints, period and colors
      logic calc_span; // absolute spans and step directions
      logic calc_init; // major axis, error start, divider setup
      logic div_step;  // one bit of the start residue division
      logic fix_res;   // turn remainder into residue of signed coordinate
      logic emit;      // emit current pixel and step
   } cmd_type;

   typedef struct packed {
      logic div_done;  // this divider step is the last one
      logic at_end;    // current point equals the end point
      logic slot_free; // output register can take a word this cycle
   } stat_type;

endpackage

/* rtl/dlr_ctrl.sv */
// dotted line rasterizer controller: sequences line setup, the start
// residue division and pixel stepping; uses dlr_pkg

module dlr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_kind,
   output logic              req_tready,
   input  dlr_pkg::stat_type stat,
   output dlr_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SPAN  = 6'b000010,
      ST_INIT  = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_FIX   = 6'b010000,
      ST_RUN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            // an advance while idle is taken and dropped
            req_tready = 1'b1;
            if (req_tvalid && req_kind == dlr_pkg::REQ_LOAD) begin
               cmd.load = 1'b1;
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            cmd.calc_span = 1'b1;
            state_in      = ST_INIT;
         end
         ST_INIT: begin
            cmd.calc_init = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix_res = 1'b1;
            state_in    = ST_RUN;
         end
         ST_RUN: begin
            req_tready = stat.slot_free;
            if (req_tvalid && stat.slot_free) begin
               if (req_kind == dlr_pkg::REQ_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = ST_SPAN;
               end else begin
                  cmd.emit = 1'b1;
                  if (stat.at_end) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/dlr_dp.sv */
// dotted line rasterizer datapath: line registers, bresenham step,
// bit-serial start residue divider, dot residue counter and output word
// uses dlr_pkg, driven by dlr_ctrl

module dlr_dp #(
   parameter int COORD_WIDTH = dlr_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dlr_pkg::cmd_type                     cmd,
   output dlr_pkg::stat_type                    stat,
   input  logic signed [COORD_WIDTH-1:0]        start_x,
   input  logic signed [COORD_WIDTH-1:0]        start_y,
   input  logic signed [COORD_WIDTH-1:0]        end_x,
   input  logic signed [COORD_WIDTH-1:0]        end_y,
   input  logic [dlr_pkg::PERIOD_WIDTH-1:0]     dot_period,
   input  logic [dlr_pkg::COLOR_WIDTH-1:0]      on_color,
   input  logic [dlr_pkg::COLOR_WIDTH-1:0]      off_color,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [COORD_WIDTH-1:0]        pixel_x,
   output logic signed [COORD_WIDTH-1:0]        pixel_y,
   output logic [dlr_pkg::COLOR_WIDTH-1:0]      pixel_color,
   output logic                                 last
);

   localparam int W   = COORD_WIDTH;
   localparam int EW  = COORD_WIDTH + 2;
   localparam int PW  = dlr_pkg::PERIOD_WIDTH;
   localparam int CW  = dlr_pkg::COLOR_WIDTH;
   localparam int CNT = $clog2(COORD_WIDTH);

   logic signed [W-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [W-1:0]  goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [W:0]           span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic                 down_x_ff, down_x_in, down_y_ff, down_y_in;
   logic                 x_major_ff, x_major_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic [PW-1:0]        period_ff, period_in;
   logic [CW-1:0]        dot_color_ff, dot_color_in, gap_color_ff, gap_color_in;
   logic [W-1:0]         quo_ff, quo_in;
   logic [PW-1:0]        rem_ff, rem_in;
   logic [CNT-1:0]       cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [PW-1:0]        residue_ff, residue_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]  pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic [CW-1:0]        pix_color_ff, pix_color_in;
   logic                 last_ff, last_in;

   logic signed [W:0]    dx, dy;
   logic                 major_x_sel;
   logic signed [W-1:0]  major_start;
   logic [W-1:0]         major_mag;
   logic [PW:0]          trial;
   logic signed [EW-1:0] span_x_ext, span_y_ext;
   logic                 step_x, step_y, at_end, major_steps, major_down;

   assign dx = {goal_x_ff[W-1], goal_x_ff} - {cur_x_ff[W-1], cur_x_ff};
   assign dy = {goal_y_ff[W-1], goal_y_ff} - {cur_y_ff[W-1], cur_y_ff};

   assign major_x_sel = span_x_ff > span_y_ff;
   assign major_start = major_x_sel ? cur_x_ff : cur_y_ff;
   assign major_mag   = major_start[W-1] ? (~major_start + 1'b1) : major_start;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[W-1]};

   assign span_x_ext = {1'b0, span_x_ff};
   assign span_y_ext = {1'b0, span_y_ff};
   assign step_x     = err_ff > -span_x_ext;
   assign step_y     = err_ff < span_y_ext;
   assign at_end     = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);
   assign major_steps = x_major_ff ? step_x : step_y;
   assign major_down  = x_major_ff ? down_x_ff : down_y_ff;

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      down_x_in    = down_x_ff;
      down_y_in    = down_y_ff;
      x_major_in   = x_major_ff;
      err_in       = err_ff;
      period_in    = period_ff;
      dot_color_in = dot_color_ff;
      gap_color_in = gap_color_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      residue_in   = residue_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      pix_color_in = pix_color_ff;
      last_in      = last_ff;

      if (cmd.load) begin
         cur_x_in     = start_x;
         cur_y_in     = start_y;
         goal_x_in    = end_x;
         goal_y_in    = end_y;
         period_in    = (dot_period == '0) ? PW'(1) : dot_period;
         dot_color_in = on_color;
         gap_color_in = off_color;
      end

      if (cmd.calc_span) begin
         span_x_in = dx[W] ? (W + 1)'(-dx) : (W + 1)'(dx);
         span_y_in = dy[W] ? (W + 1)'(-dy) : (W + 1)'(dy);
         down_x_in = dx[W] || (dx == '0);
         down_y_in = dy[W] || (dy == '0);
      end

      if (cmd.calc_init) begin
         x_major_in = major_x_sel;
         err_in     = major_x_sel ? $signed({2'b00, span_x_ff[W:1]})
                                  : -$signed({2'b00, span_y_ff[W:1]});
         quo_in     = major_mag;
         neg_in     = major_start[W-1];
         rem_in     = '0;
         cnt_in     = '0;
      end

      if (cmd.div_step) begin
         if (trial >= {1'b0, period_ff}) begin
            rem_in = PW'(trial - {1'b0, period_ff});
         end else begin
            rem_in = trial[PW-1:0];
         end
         quo_in = {quo_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.fix_res) begin
         // residue of the signed coordinate, always in 0 .. period-1
         residue_in = (neg_ff && rem_ff != '0) ? (period_ff - rem_ff) : rem_ff;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         pix_x_in     = cur_x_ff;
         pix_y_in     = cur_y_ff;
         pix_color_in = (residue_ff == '0) ? dot_color_ff : gap_color_ff;
         last_in      = at_end;
         if (!at_end) begin
            err_in = err_ff - (step_x ? span_y_ext : EW'(0))
                            + (step_y ? span_x_ext : EW'(0));
            if (step_x) begin
               cur_x_in = cur_x_ff + (down_x_ff ? {W{1'b1}} : W'(1));
            end
            if (step_y) begin
               cur_y_in = cur_y_ff + (down_y_ff ? {W{1'b1}} : W'(1));
            end
            if (major_steps) begin
               if (major_down) begin
                  residue_in = (residue_ff == '0) ? (period_ff - 1'b1)
                                                  : (residue_ff - 1'b1);
               end else begin
                  residue_in = (residue_ff == period_ff - 1'b1) ? PW'(0)
                                                                : (residue_ff + 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         period_ff    <= PW'(1);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      goal_x_ff    <= goal_x_in;
      goal_y_ff    <= goal_y_in;
      span_x_ff    <= span_x_in;
      span_y_ff    <= span_y_in;
      down_x_ff    <= down_x_in;
      down_y_ff    <= down_y_in;
      x_major_ff   <= x_major_in;
      err_ff       <= err_in;
      dot_color_ff <= dot_color_in;
      gap_color_ff <= gap_color_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      residue_ff   <= residue_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      pix_color_ff <= pix_color_in;
      last_ff      <= last_in;
   end

   assign stat.div_done  = cnt_ff == CNT'(W - 1);
   assign stat.at_end    = at_end;
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign pixel_x     = pix_x_ff;
   assign pixel_y     = pix_y_ff;
   assign pixel_color = pix_color_ff;
   assign last        = last_ff;

endmodule

/* rtl/dotted_line_rasterizer.sv */
// dotted line rasterizer top level: stream ports, controller and datapath
// uses dlr_pkg, dlr_ctrl, dlr_dp

// An all-octant Bresenham line generator with a dotted color pattern. A load
// word (req_tuser = 0) latches start and end points, dot period and two colors
// and gives no output; each advance word (req_tuser = 1) then gives one pixel,
// start to end inclusive, with rsp_tlast on the end point. A pixel gets
// on_color when its major-axis coordinate is a multiple of the period (0 acts
// as 1). An advance with no line running is taken and dropped; a load during a
// line drops the running line. Advances run at one pixel per clock while the
// output is taken. A load keeps the input stalled after it is taken while the
// line is set up (span, setup, one divider step per coordinate bit for the
// start residue, fixup).

module dotted_line_rasterizer #(
   parameter int COORD_WIDTH = dlr_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, end_x, end_y, dot_period, on_color, off_color, zero pad
   input  logic [((4 * COORD_WIDTH + 3 * dlr_pkg::COLOR_WIDTH + 7) / 8) * 8 - 1:0]
                req_tdata,
   // req_type
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero pad
   output logic [((2 * COORD_WIDTH + dlr_pkg::COLOR_WIDTH + 7) / 8) * 8 - 1:0]
                rsp_tdata,
   output logic rsp_tlast
);

   localparam int W       = COORD_WIDTH;
   localparam int PW      = dlr_pkg::PERIOD_WIDTH;
   localparam int CW      = dlr_pkg::COLOR_WIDTH;
   localparam int RSP_W   = ((2 * COORD_WIDTH + dlr_pkg::COLOR_WIDTH + 7) / 8) * 8;
   localparam int P_LO    = 4 * W;
   localparam int ON_LO   = 4 * W + PW;
   localparam int OFF_LO  = 4 * W + PW + CW;

   dlr_pkg::cmd_type  cmd;
   dlr_pkg::stat_type stat;

   logic signed [W-1:0] pixel_x, pixel_y;
   logic [CW-1:0]       pixel_color;

   dlr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dlr_dp #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .start_x     (req_tdata[W-1:0]),
      .start_y     (req_tdata[2*W-1:W]),
      .end_x       (req_tdata[3*W-1:2*W]),
      .end_y       (req_tdata[4*W-1:3*W]),
      .dot_period  (req_tdata[P_LO+PW-1:P_LO]),
      .on_color    (req_tdata[ON_LO+CW-1:ON_LO]),
      .off_color   (req_tdata[OFF_LO+CW-1:OFF_LO]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_color (pixel_color),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({pixel_color, pixel_y, pixel_x});

`ifndef SYNTHESIS
   // setup phase holds off the input after a load
   a_load_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == dlr_pkg::REQ_LOAD) |=> !req_tready)
      else $error("input not stalled after load");

   // a pixel is only produced when the output register can take it
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("pixel produced over a pending word");

   // after the end point the block is idle and takes input again
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.at_end) |=> req_tready)
      else $error("not idle after end point");

   // only one controller command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("overlapping datapath commands");
`endif

endmodule
